// ----- src/rtcc_pkg.sv -----
// Package for the calendar clock with resync sequencer.
// Holds the transfer payload types, event codes and sequencer codes.
// No dependencies.
package rtcc_pkg;

    // event kinds
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_STEP   = 2'd1;
    localparam logic [1:0] FUNC_SYNC   = 2'd2;
    localparam logic [1:0] FUNC_SERVER = 2'd3;

    // sequencer states
    localparam logic [1:0] ST_INIT    = 2'd0;
    localparam logic [1:0] ST_RESOLVE = 2'd1;
    localparam logic [1:0] ST_SYNCING = 2'd2;
    localparam logic [1:0] ST_SYNCED  = 2'd3;

    localparam logic [15:0] SYNC_INTERVAL_RESET = 16'd3600;

    // year divisible by 25: y * inv(25) mod 2^16 falls at or below (2^16-1)/25
    localparam logic [15:0] INV25_MOD16 = 16'd23593;
    localparam logic [15:0] DIV25_LIMIT = 16'd2621;

    typedef struct packed {
        logic [1:0]  func;
        logic        dns_ok;
        logic        sntp_ok;
        logic [15:0] new_year;
        logic [3:0]  new_month;
        logic [4:0]  new_day;
        logic [4:0]  new_hour;
        logic [5:0]  new_minute;
        logic [5:0]  new_second;
    } t_rtcc_in;

    typedef struct packed {
        logic [1:0]  mode;
        logic        time_valid;
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        dns_request;
        logic        sntp_start;
        logic        request_refused;
    } t_rtcc_out;

endpackage

// ----- src/rtc_calendar_with_sync_control.sv -----
// Top level of the calendar clock with resync sequencer.
// Depends on rtcc_pkg for payload types and codes.
// Each event updates the counter, calendar and sequencer state in the cycle it is accepted.

// Usage: one event is taken per clock cycle and its result appears in the
// output register on the next cycle, so the rate is one item per cycle unless
// stalled. All state (second counter, calendar, sequencer) is updated in the
// cycle the event is accepted; the single output register decouples the two
// sides, and o_in_ready is high whenever that register is empty or is being
// taken in the same cycle. The sync interval is written through i_cfg_we and
// i_cfg_wdata and resets to 3600 seconds; zero turns periodic resync off.
module rtc_calendar_with_sync_control import rtcc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_rtcc_in  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_rtcc_out o_out,
    input  logic      i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    logic [15:0] r_interval;
    logic [31:0] r_sec_cnt,  n_sec_cnt;
    logic [31:0] r_last_cnt, n_last_cnt;
    logic [1:0]  r_state,    n_state;
    logic        r_resolved, n_resolved;
    logic        r_qready,   n_qready;
    logic        r_pending,  n_pending;
    logic [15:0] r_year,     n_year;
    logic [3:0]  r_month,    n_month;
    logic [4:0]  r_day,      n_day;
    logic [4:0]  r_hour,     n_hour;
    logic [5:0]  r_minute,   n_minute;
    logic [5:0]  r_second,   n_second;
    logic        r_out_valid;
    t_rtcc_out   r_out,      n_out;

    logic        accept;
    logic [15:0] y_mul;
    logic        div25;
    logic        leap;
    logic [4:0]  mlen;
    logic [5:0]  day_inc;
    logic [4:0]  month_inc;
    logic [31:0] since_sync;
    logic        interval_due;
    logic        dns_req, q_start, refused;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Gregorian leap test on the current year
    assign y_mul = r_year * INV25_MOD16;
    assign div25 = (y_mul <= DIV25_LIMIT);
    assign leap  = (r_year[3:0] == 4'd0 && div25) || (r_year[1:0] == 2'd0 && !div25);

    always_comb begin
        case (r_month)
            4'd4, 4'd6, 4'd9, 4'd11: mlen = 5'd30;
            4'd2:                    mlen = leap ? 5'd29 : 5'd28;
            default:                 mlen = 5'd31;
        endcase
    end

    assign day_inc      = {1'b0, r_day} + 6'd1;
    assign month_inc    = {1'b0, r_month} + 5'd1;
    assign since_sync   = r_sec_cnt - r_last_cnt;
    assign interval_due = (r_interval != 16'd0) && (since_sync >= {16'd0, r_interval});

    always_comb begin
        n_sec_cnt  = r_sec_cnt;
        n_last_cnt = r_last_cnt;
        n_state    = r_state;
        n_resolved = r_resolved;
        n_qready   = r_qready;
        n_pending  = r_pending;
        n_year     = r_year;
        n_month    = r_month;
        n_day      = r_day;
        n_hour     = r_hour;
        n_minute   = r_minute;
        n_second   = r_second;
        dns_req    = 1'b0;
        q_start    = 1'b0;
        refused    = 1'b0;

        case (i_in.func)
            FUNC_TICK: begin
                n_sec_cnt = r_sec_cnt + 32'd1;
                // calendar only runs once a real year is held
                if (r_year != 16'd0) begin
                    if (r_second < 6'd59) begin
                        n_second = r_second + 6'd1;
                    end else begin
                        n_second = 6'd0;
                        if (r_minute < 6'd59) begin
                            n_minute = r_minute + 6'd1;
                        end else begin
                            n_minute = 6'd0;
                            if (r_hour < 5'd23) begin
                                n_hour = r_hour + 5'd1;
                            end else begin
                                n_hour = 5'd0;
                                if (day_inc > {1'b0, mlen}) begin
                                    n_day = 5'd1;
                                    if (month_inc > 5'd12) begin
                                        n_month = 4'd1;
                                        n_year  = r_year + 16'd1;
                                    end else begin
                                        n_month = month_inc[3:0];
                                    end
                                end else begin
                                    n_day = day_inc[4:0];
                                end
                            end
                        end
                    end
                end
            end
            FUNC_STEP: begin
                case (r_state)
                    ST_INIT: begin
                        n_resolved = 1'b0;
                        n_state    = ST_RESOLVE;
                    end
                    ST_RESOLVE: begin
                        if (!r_resolved) begin
                            dns_req = 1'b1;
                            if (i_in.dns_ok) begin
                                n_resolved = 1'b1;
                                q_start    = 1'b1;
                                n_qready   = 1'b1;
                                n_state    = ST_SYNCING;
                            end
                        end else begin
                            q_start  = 1'b1;
                            n_qready = 1'b1;
                            n_state  = ST_SYNCING;
                        end
                    end
                    ST_SYNCING: begin
                        if (!r_qready) begin
                            n_state = ST_RESOLVE;
                        end else if (i_in.sntp_ok) begin
                            n_year     = i_in.new_year;
                            n_month    = i_in.new_month;
                            n_day      = i_in.new_day;
                            n_hour     = i_in.new_hour;
                            n_minute   = i_in.new_minute;
                            n_second   = i_in.new_second;
                            n_last_cnt = r_sec_cnt;
                            n_pending  = 1'b0;
                            n_state    = ST_SYNCED;
                        end
                    end
                    default: begin
                        if (r_pending || interval_due) begin
                            n_resolved = 1'b0;
                            n_qready   = 1'b0;
                            n_state    = ST_RESOLVE;
                        end
                    end
                endcase
            end
            FUNC_SYNC: begin
                if (r_state == ST_SYNCING) begin
                    refused = 1'b1;
                end else begin
                    n_pending  = 1'b1;
                    n_resolved = 1'b0;
                    n_state    = ST_RESOLVE;
                end
            end
            default: begin
                n_resolved = 1'b0;
                n_state    = ST_RESOLVE;
            end
        endcase

        n_out.mode            = n_state;
        n_out.time_valid      = (n_year != 16'd0);
        n_out.year            = n_year;
        n_out.month           = n_month;
        n_out.day             = n_day;
        n_out.hour            = n_hour;
        n_out.minute          = n_minute;
        n_out.second          = n_second;
        n_out.dns_request     = dns_req;
        n_out.sntp_start      = q_start;
        n_out.request_refused = refused;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval  <= SYNC_INTERVAL_RESET;
            r_sec_cnt   <= 32'd0;
            r_last_cnt  <= 32'd0;
            r_state     <= ST_INIT;
            r_resolved  <= 1'b0;
            r_qready    <= 1'b0;
            r_pending   <= 1'b0;
            r_year      <= 16'd0;
            r_month     <= 4'd0;
            r_day       <= 5'd0;
            r_hour      <= 5'd0;
            r_minute    <= 6'd0;
            r_second    <= 6'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_interval <= i_cfg_wdata;
            end
            if (accept) begin
                r_sec_cnt  <= n_sec_cnt;
                r_last_cnt <= n_last_cnt;
                r_state    <= n_state;
                r_resolved <= n_resolved;
                r_qready   <= n_qready;
                r_pending  <= n_pending;
                r_year     <= n_year;
                r_month    <= n_month;
                r_day      <= n_day;
                r_hour     <= n_hour;
                r_minute   <= n_minute;
                r_second   <= n_second;
            end
            // hold the result until transfer, refill on accept
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- src/rtcc_checker.sv -----
// Port-level checker for the calendar clock with resync sequencer.
// Depends on rtcc_pkg; bound to rtc_calendar_with_sync_control below.
module rtcc_checker import rtcc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_rtcc_out o_out
);

    // a waiting result stays until transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result dropped or changed while stalled");

    a_valid_year: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.time_valid == (o_out.year != 16'd0))
        else $error("time_valid disagrees with year");

    a_refused_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.request_refused |-> o_out.mode == ST_SYNCING)
        else $error("refusal outside syncing");

    a_start_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.sntp_start |-> o_out.mode == ST_SYNCING
            && !o_out.request_refused)
        else $error("query start without entering syncing");

    a_dns_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.dns_request && !o_out.sntp_start
            |-> o_out.mode == ST_RESOLVE)
        else $error("failed resolution left resolve");

endmodule

bind rtc_calendar_with_sync_control rtcc_checker u_rtcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
